[rtl/blmf_pkg.sv]
// ----------------------------------------------------------------------------
// blmf_pkg: shared types and constants for the bicolor LED matrix frame buffer
// Command codes, CSR indexes, frame layout and the request/response beats.
// ----------------------------------------------------------------------------
`default_nettype none

package blmf_pkg;

   // command codes
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_SEND  = 2'd2;

   // CSR indexes
   localparam logic CSR_ROTATION = 1'b0;
   localparam logic CSR_BAR      = 1'b1;
   localparam int   CSR_DATA_W   = 16;

   // matrix geometry
   localparam int         ROWS      = 8;
   localparam int         ROW_W     = 16;
   localparam logic [2:0] MAX_COORD = 3'd7;

   // frame layout: 'b', bar hi, bar lo, 'm', then 8 rows as hi/lo pairs
   localparam int         FRAME_LEN  = 20;
   localparam int         POS_W      = 5;
   localparam logic [4:0] POS_BAR_HI = 5'd1;
   localparam logic [4:0] POS_BAR_LO = 5'd2;
   localparam logic [4:0] POS_MARK   = 5'd3;
   localparam logic [4:0] POS_START  = 5'd0;
   localparam logic [4:0] POS_ROWS   = 5'd4;
   localparam logic [4:0] POS_LAST   = 5'(FRAME_LEN - 1);
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_M     = 8'h6D;

   // rotation quadrants
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] pixel_x;
      logic [2:0] pixel_y;
      logic [1:0] pixel_color;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

endpackage : blmf_pkg

`default_nettype wire

[rtl/bicolor_led_matrix_framebuffer_unit.sv]
// ----------------------------------------------------------------------------
// bicolor_led_matrix_framebuffer_unit: 8x8 red/green LED frame buffer
// Holds eight 16-bit pixel rows, writes pixels through a rotation and dumps
// the frame as a 20-beat byte burst.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken on a clock edge with start high and busy
//   low. Clear and set pixel act on the row registers at that very edge, so
//   they go at one beat per cycle while busy is low and produce no response.
//   Send frame raises busy while the byte counter walks the frame; one
//   response beat per cycle leaves through the output register, from the
//   cycle after busy rises: 'b', bar hi, bar lo, 'm', then row 0..7 as high
//   byte then low byte. rsp_strobe marks each beat; last_byte flags beat 20.
//   A new command is taken in the cycle that shows the last byte. Throughput
//   is set by the single byte counter: one frame byte per clock.
//   The receiver cannot stall: every strobed beat is final.
//   CSR writes (rotation, bar value) take effect on the write edge and are to
//   be issued only while busy is low and no response is pending.
//   Reset (synchronous, active high) clears the pixels, the CSRs, the counter
//   and busy; no response is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module bicolor_led_matrix_framebuffer_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   // command channel
   input  wire                                  start,
   output logic                                 busy,
   input  blmf_pkg::req_type                    req_payload,
   // response channel
   output logic                                 rsp_strobe,
   output blmf_pkg::rsp_type                    rsp_payload,
   // CSR write port
   input  wire                                  csr_we,
   input  wire                                  csr_index,
   input  wire [blmf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // ---------------------------------------------------------------- state
   logic [blmf_pkg::ROW_W-1:0] rows_ff [blmf_pkg::ROWS];
   logic [1:0]                 rot_ff;
   logic [15:0]                bar_ff;
   logic                       busy_ff;
   logic [blmf_pkg::POS_W-1:0] pos_ff;
   logic                       rsp_valid_ff;
   blmf_pkg::rsp_type          rsp_ff;

   // ---------------------------------------------------------------- decode
   logic accept;
   logic do_clear;
   logic do_set;
   logic do_send;
   logic send_last;

   assign accept    = start && !busy_ff;
   assign do_clear  = accept && (req_payload.command == blmf_pkg::CMD_CLEAR);
   assign do_set    = accept && (req_payload.command == blmf_pkg::CMD_SET);
   assign do_send   = accept && (req_payload.command == blmf_pkg::CMD_SEND);
   assign send_last = (pos_ff == blmf_pkg::POS_LAST);

   // ------------------------------------------------------ rotation mapping
   logic [2:0] map_col;
   logic [2:0] map_row;

   always_comb begin
      case (rot_ff)
         blmf_pkg::ROT_0: begin
            map_col = blmf_pkg::MAX_COORD - req_payload.pixel_y;
            map_row = req_payload.pixel_x;
         end
         blmf_pkg::ROT_90: begin
            map_col = blmf_pkg::MAX_COORD - req_payload.pixel_x;
            map_row = blmf_pkg::MAX_COORD - req_payload.pixel_y;
         end
         blmf_pkg::ROT_180: begin
            map_col = req_payload.pixel_y;
            map_row = blmf_pkg::MAX_COORD - req_payload.pixel_x;
         end
         default: begin
            // 270 deg is the identity
            map_col = req_payload.pixel_x;
            map_row = req_payload.pixel_y;
         end
      endcase
   end

   // ------------------------------------------------------------- row read
   // One read port: the send walk owns it while busy, pixel writes otherwise.
   logic [blmf_pkg::POS_W-1:0] row_offset;
   logic [2:0]                 rd_row;
   logic [blmf_pkg::ROW_W-1:0] rd_data;

   assign row_offset = pos_ff - blmf_pkg::POS_ROWS;
   assign rd_row     = busy_ff ? row_offset[3:1] : map_row;
   assign rd_data    = rows_ff[rd_row];

   // read-modify-write of the pixel's two bits
   logic [blmf_pkg::ROW_W-1:0] row_in;

   always_comb begin
      row_in = rd_data;
      for (int c = 0; c < 8; c++) begin
         if (map_col == 3'(c)) begin
            row_in[2*c +: 2] = req_payload.pixel_color;
         end
      end
   end

   // ------------------------------------------------------------ byte select
   logic [7:0] byte_in;

   always_comb begin
      case (pos_ff)
         blmf_pkg::POS_START:  byte_in = blmf_pkg::CHAR_B;
         blmf_pkg::POS_BAR_HI: byte_in = bar_ff[15:8];
         blmf_pkg::POS_BAR_LO: byte_in = bar_ff[7:0];
         blmf_pkg::POS_MARK:   byte_in = blmf_pkg::CHAR_M;
         default:              byte_in = row_offset[0] ? rd_data[7:0] : rd_data[15:8];
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < blmf_pkg::ROWS; r++) begin
            rows_ff[r] <= '0;
         end
      end else if (do_clear) begin
         for (int r = 0; r < blmf_pkg::ROWS; r++) begin
            rows_ff[r] <= '0;
         end
      end else if (do_set) begin
         rows_ff[map_row] <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff <= blmf_pkg::ROT_0;
         bar_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == blmf_pkg::CSR_ROTATION) begin
            rot_ff <= csr_wdata[1:0];
         end else begin
            bar_ff <= csr_wdata;
         end
      end
   end

   // frame walk: busy spans the walk over all frame bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= blmf_pkg::POS_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= busy_ff;
         if (do_send) begin
            busy_ff <= 1'b1;
            pos_ff  <= blmf_pkg::POS_START;
         end else if (busy_ff) begin
            if (send_last) begin
               busy_ff <= 1'b0;
               pos_ff  <= blmf_pkg::POS_START;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rsp_ff.frame_byte <= byte_in;
         rsp_ff.last_byte  <= send_last;
      end
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ------------------------------------------------------------ assertions
`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff <= blmf_pkg::POS_LAST))
      else $error("frame position beyond last byte");

   a_beat_from_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy_ff))
      else $error("response beat without frame walk");

   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && send_last) |=> (!busy_ff && rsp_strobe && rsp_payload.last_byte))
      else $error("frame walk did not end with the last byte");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.last_byte) |=> !rsp_strobe)
      else $error("beat directly after the last byte");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !send_last) |=> busy_ff)
      else $error("walk ended early");
`endif

endmodule : bicolor_led_matrix_framebuffer_unit

`default_nettype wire

[test/bicolor_led_matrix_framebuffer_unit_tb.sv]
// ----------------------------------------------------------------------------
// bicolor_led_matrix_framebuffer_unit_tb: self-checking bench for the LED frame buffer
// Feeds clear, set-pixel and send-frame commands in random bursts, keeps a shadow
// copy of the pixel rows and CSRs, and checks every frame byte beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bicolor_led_matrix_framebuffer_unit_tb;
   import blmf_pkg::*;

   // codes the package does not name
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] ROT_270    = 2'd3;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 57;
   localparam int SETTLE_CYCLES   = 24;
   localparam int REPORT_LIMIT    = 10;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic                  busy;
   req_type               req_payload = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_payload;
   logic                  csr_we      = 1'b0;
   logic                  csr_index   = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   bicolor_led_matrix_framebuffer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Shadow state: pixel rows, advanced once per accepted beat, plus CSR copies.
   // --------------------------------------------------------------------------
   logic [ROW_W-1:0]      shadow_rows [ROWS];
   logic [1:0]            shadow_rotation = ROT_0;
   logic [CSR_DATA_W-1:0] shadow_bar      = '0;

   rsp_type pending_frame_bytes [$];   // frame bytes still owed by the DUT
   req_type command_queue [$];         // commands waiting for the driver

   int queued_count   = 0;
   int taken_count    = 0;
   int mismatch_count = 0;

   initial begin
      foreach (shadow_rows[i]) shadow_rows[i] = '0;
   end

   // Apply one accepted command to the shadow; a send queues its 20 bytes.
   task automatic apply_command(input req_type cmd);
      logic [2:0]       col;
      logic [2:0]       row;
      logic [4:0]       offset;
      logic [ROW_W-1:0] word;
      rsp_type          beat;
      case (cmd.command)
         CMD_CLEAR: begin
            foreach (shadow_rows[i]) shadow_rows[i] = '0;
         end
         CMD_SET: begin
            // quarter-turn mapping from (x,y) to (column,row)
            case (shadow_rotation)
               ROT_0: begin
                  col = MAX_COORD - cmd.pixel_y;
                  row = cmd.pixel_x;
               end
               ROT_90: begin
                  col = MAX_COORD - cmd.pixel_x;
                  row = MAX_COORD - cmd.pixel_y;
               end
               ROT_180: begin
                  col = cmd.pixel_y;
                  row = MAX_COORD - cmd.pixel_x;
               end
               default: begin   // 270 degrees is the identity
                  col = cmd.pixel_x;
                  row = cmd.pixel_y;
               end
            endcase
            shadow_rows[row][2*col +: 2] = cmd.pixel_color;
         end
         CMD_SEND: begin
            for (int pos = 0; pos < FRAME_LEN; pos++) begin
               offset = 5'(pos) - POS_ROWS;
               word   = shadow_rows[offset[3:1]];
               case (5'(pos))
                  POS_START:  beat.frame_byte = CHAR_B;
                  POS_BAR_HI: beat.frame_byte = shadow_bar[15:8];
                  POS_BAR_LO: beat.frame_byte = shadow_bar[7:0];
                  POS_MARK:   beat.frame_byte = CHAR_M;
                  default:    beat.frame_byte = offset[0] ? word[7:0] : word[15:8];
               endcase
               beat.last_byte = (5'(pos) == POS_LAST);
               pending_frame_bytes.push_back(beat);
            end
         end
         default: ;   // unused code: no state change, no bytes
      endcase
   endtask

   // --------------------------------------------------------------------------
   // Driver: one command beat per free slot, in bursts with random gaps.
   // During a gap start is low and the payload carries noise.
   // --------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_command(req_payload);
            taken_count++;
         end
         // slot is free unless a beat is still held off by busy
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start       <= 1'b0;
               req_payload <= req_type'($urandom);
            end else if (command_queue.size() > 0) begin
               start       <= 1'b1;
               req_payload <= command_queue.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  // about a quarter of the bursts run back to back
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: every strobed beat is final, compare it against the oldest byte.
   // --------------------------------------------------------------------------
   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_frame_bytes.size() == 0) begin
            note_mismatch($sformatf("beat with nothing owed: byte %02h last %0b",
                                    rsp_payload.frame_byte, rsp_payload.last_byte));
         end else begin
            want = pending_frame_bytes.pop_front();
            if (rsp_payload.frame_byte !== want.frame_byte)
               note_mismatch($sformatf("frame_byte expected %02h got %02h",
                                       want.frame_byte, rsp_payload.frame_byte));
            if (rsp_payload.last_byte !== want.last_byte)
               note_mismatch($sformatf("last_byte expected %0b got %0b",
                                       want.last_byte, rsp_payload.last_byte));
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   task automatic queue_command(input logic [1:0] op, input logic [2:0] x,
                                input logic [2:0] y, input logic [1:0] color);
      req_type cmd;
      cmd.command     = op;
      cmd.pixel_x     = x;
      cmd.pixel_y     = y;
      cmd.pixel_color = color;
      command_queue.push_back(cmd);
      queued_count++;
   endtask

   // Quiet point: every command taken, every byte seen, plus a little slack.
   task automatic wait_quiet();
      while (taken_count != queued_count || pending_frame_bytes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // CSR beat; after the write the CSR index and data lines carry random junk.
   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_ROTATION) shadow_rotation = value[1:0];
      else                     shadow_bar      = value;
      @(posedge clock);
      csr_we    <= 1'b0;
      csr_index <= 1'($urandom);
      csr_wdata <= CSR_DATA_W'($urandom);
   endtask

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      logic [1:0] op;
      int         pick;
      int         counted;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset CSRs (rotation 0, bar 0)
      queue_command(CMD_SEND, 3'd0, 3'd0, 2'd0);            // empty frame
      queue_command(CMD_SET, 3'd0, 3'd0, 2'd3);             // corners
      queue_command(CMD_SET, 3'd7, 3'd7, 2'd1);
      queue_command(CMD_SET, 3'd0, 3'd7, 2'd2);
      queue_command(CMD_SET, 3'd7, 3'd0, 2'd3);
      queue_command(CMD_SET, 3'd3, 3'd4, 2'd3);
      queue_command(CMD_SET, 3'd3, 3'd4, 2'd0);             // overwrite to black
      queue_command(CMD_SEND, 3'd7, 3'd7, 2'd3);            // pixel fields ignored
      queue_command(CMD_UNUSED, 3'd7, 3'd7, 2'd3);          // unused code ignored
      queue_command(CMD_SEND, 3'd0, 3'd0, 2'd0);
      queue_command(CMD_CLEAR, 3'd7, 3'd7, 2'd3);           // fields ignored on clear
      queue_command(CMD_SEND, 3'd5, 3'd2, 2'd1);
      wait_quiet();

      // directed: identity rotation, bar all ones
      write_csr(CSR_ROTATION, {14'h3FFF, ROT_270});
      write_csr(CSR_BAR, 16'hFFFF);
      queue_command(CMD_SET, 3'd7, 3'd7, 2'd3);
      queue_command(CMD_SET, 3'd0, 3'd0, 2'd1);
      queue_command(CMD_SET, 3'd7, 3'd0, 2'd2);
      queue_command(CMD_SEND, 3'd0, 3'd0, 2'd0);
      queue_command(CMD_CLEAR, 3'd0, 3'd0, 2'd0);
      queue_command(CMD_SEND, 3'd0, 3'd0, 2'd0);
      wait_quiet();

      // random phases: each rotation twice, bar at both extremes and random
      for (int ph = 0; ph < PHASES; ph++) begin
         write_csr(CSR_ROTATION, {14'($urandom), 2'(ph)});
         write_csr(CSR_BAR, (ph == 0) ? 16'h0000 :
                            (ph == 1) ? 16'hFFFF : 16'($urandom));
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if      (pick < 70) op = CMD_SET;
            else if (pick < 88) op = CMD_SEND;
            else if (pick < 94) op = CMD_CLEAR;
            else                op = CMD_UNUSED;
            queue_command(op, 3'($urandom), 3'($urandom), 2'($urandom));
            if (op != CMD_UNUSED) counted++;
         end
         // sender holds off here until the DUT has drained
         wait_quiet();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

endmodule : bicolor_led_matrix_framebuffer_unit_tb

`default_nettype wire

[filelist.f]
rtl/blmf_pkg.sv
rtl/bicolor_led_matrix_framebuffer_unit.sv
test/bicolor_led_matrix_framebuffer_unit_tb.sv
